// ----- sv/g3s_pkg.sv -----
// Shared types, constants and arithmetic helpers for the 3x3 grid smoother.
package g3s_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned CFG_W_W  = 11;
  localparam int unsigned CFG_H_W  = 13;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Register map (selected by paddr[2])
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [CFG_W_W-1:0] GRID_W_RST = 11'd1024;
  localparam logic [CFG_H_W-1:0] GRID_H_RST = 13'd1024;

  // Output queue geometry
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_DEPTH = 1 << OQ_AW;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // One vertical column of the window: top, middle, bottom
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } win_col_t;

  // One result transaction
  typedef struct packed {
    sum_t             smoothed;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } result_t;

  // Per-item control flags carried into the compute stage
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic row_lt_h;
    logic col_zero;
    logic col_last;
  } item_ctl_t;

  // Vertical [1 2 1] weighting of one column, exact in SUM_W bits
  function automatic sum_t col_sum(win_col_t x);
    sum_t a;
    sum_t b;
    sum_t c;
    a = SUM_W'(x.top);
    b = SUM_W'(x.mid);
    c = SUM_W'(x.bot);
    return a + (b <<< 1) + c;
  endfunction

endpackage

// ----- sv/gaussian_3x3_grid_smoother_unit.sv -----
// Top level of the 3x3 Gaussian grid smoother with APB configuration.
// Accepts one sample per clock in raster order, while the output queue has room, and returns
// each smoothed sample ([1 2 1; 2 4 2; 1 2 1] sum, times 16, zero padded) once the sample
// that completes its window has passed the compute stage; the second result at a row end
// follows the first. The line stores are read at the accepting edge and written back
// when the item leaves the compute stage, and the second result of each row end is
// absorbed by a four-entry output queue, so rows do not stall the input when the output
// side keeps up. After the last grid
// row, send grid_width drain samples (values ignored) to flush the final row.
// A register write restarts the frame; the line stores need no clearing pass.
module gaussian_3x3_grid_smoother_unit
  import g3s_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // Sample input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // Result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [SUM_W-1:0] smoothed_o,
  output logic [ROW_W-1:0]    out_row_o,
  output logic [COL_W-1:0]    out_col_o,
  output logic                last_o
);

  localparam int unsigned CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);

  // Clamp register values to their effective range
  function automatic logic [WW-1:0] clamp_w(logic [CFG_W_W-1:0] raw);
    logic [WW-1:0] res;
    if (32'(raw) < 32'd2) begin
      res = WW'(2);
    end else if (32'(raw) > 32'(MAX_WIDTH)) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(raw);
    end
    return res;
  endfunction

  function automatic logic [RW-1:0] clamp_h(logic [CFG_H_W-1:0] raw);
    logic [RW-1:0] res;
    if (raw == '0) begin
      res = RW'(1);
    end else if (32'(raw) > 32'(MAX_HEIGHT)) begin
      res = RW'(MAX_HEIGHT);
    end else begin
      res = RW'(raw);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W_W-1:0] grid_width_q;
  logic [CFG_H_W-1:0] grid_height_q;
  logic [WW-1:0]      eff_w_q;
  logic [RW-1:0]      eff_h_q;
  logic               cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_W_RST;
      grid_height_q <= GRID_H_RST;
      eff_w_q       <= clamp_w(GRID_W_RST);
      eff_h_q       <= clamp_h(GRID_H_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GRID_WIDTH: begin
          grid_width_q <= pwdata[CFG_W_W-1:0];
          eff_w_q      <= clamp_w(pwdata[CFG_W_W-1:0]);
        end
        REG_GRID_HEIGHT: begin
          grid_height_q <= pwdata[CFG_H_W-1:0];
          eff_h_q       <= clamp_h(pwdata[CFG_H_W-1:0]);
        end
        default: begin
          grid_width_q <= grid_width_q;
        end
      endcase
    end
  end

  // Read back the raw register
  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = APB_DW'(grid_width_q);
      REG_GRID_HEIGHT: prdata = APB_DW'(grid_height_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Accept stage: raster counters, line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [CW-1:0] w_last;
  logic          in_fire;
  item_ctl_t     ctl_in;

  logic          s1_valid_q;
  logic          s1_fire;
  item_ctl_t     s1_ctl_q;
  sample_t       s1_sample_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;

  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign w_last     = CW'(eff_w_q - WW'(1));

  // Wrap out-of-range counters to the frame start
  assign col_eff = (WW'(col_q) >= eff_w_q) ? '0 : col_q;
  assign row_eff = (row_q > eff_h_q) ? '0 : row_q;

  always_comb begin
    ctl_in.row_ge1  = (row_eff != '0);
    ctl_in.row_ge2  = (row_eff > RW'(1));
    ctl_in.row_lt_h = (row_eff < eff_h_q);
    ctl_in.col_zero = (col_eff == '0);
    ctl_in.col_last = (col_eff == w_last);
  end

  // Advance column and row
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (ctl_in.col_last) begin
        col_d = '0;
        row_d = (row_eff == eff_h_q) ? '0 : row_eff + RW'(1);
      end else begin
        col_d = col_eff + CW'(1);
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage: line store data arrives, window slides, results pushed
  // ---------------------------------------------------------------------------
  sample_t  older_rd, newer_rd;
  win_col_t cur_col;
  win_col_t win_l_q, win_m_q;
  sample_t  newer_wr;
  sum_t     sum_a, sum_b;
  logic     has_a, has_b;
  result_t  res_a, res_b;
  logic [31:0] row_m1_ext;
  logic [31:0] col_ext;
  logic [31:0] col_m1_ext;

  logic [OQ_AW:0] oq_count_q;

  assign s1_fire = s1_valid_q && (oq_count_q <= (OQ_AW + 1)'(OQ_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the item payload at accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q    <= ctl_in;
      s1_sample_q <= sample_i;
      s1_col_q    <= col_eff;
      s1_row_q    <= row_eff;
    end
  end

  g3s_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rd_en_i       (in_fire),
    .rd_addr_i     (col_eff),
    .wr_en_i       (s1_fire),
    .wr_addr_i     (s1_col_q),
    .older_wdata_i (newer_rd),
    .newer_wdata_i (newer_wr),
    .older_rdata_o (older_rd),
    .newer_rdata_o (newer_rd)
  );

  // Mask rows that lie above the grid or below its last row
  assign newer_wr    = s1_ctl_q.row_lt_h ? s1_sample_q : '0;
  assign cur_col.top = s1_ctl_q.row_ge2 ? older_rd : '0;
  assign cur_col.mid = s1_ctl_q.row_ge1 ? newer_rd : '0;
  assign cur_col.bot = newer_wr;

  // Kernel sums: centered on previous column, and on current column at row end
  assign sum_a = col_sum(win_l_q) + (col_sum(win_m_q) <<< 1) + col_sum(cur_col);
  assign sum_b = col_sum(win_m_q) + (col_sum(cur_col) <<< 1);

  assign has_a = s1_ctl_q.row_ge1 && !s1_ctl_q.col_zero;
  assign has_b = s1_ctl_q.row_ge1 && s1_ctl_q.col_last;

  assign row_m1_ext = 32'(s1_row_q - RW'(1));
  assign col_ext    = 32'(s1_col_q);
  assign col_m1_ext = 32'(s1_col_q - CW'(1));

  always_comb begin
    res_a.smoothed = sum_a;
    res_a.row      = row_m1_ext[ROW_W-1:0];
    res_a.col      = col_m1_ext[COL_W-1:0];
    res_a.last     = !s1_ctl_q.col_last;
    res_b.smoothed = sum_b;
    res_b.row      = row_m1_ext[ROW_W-1:0];
    res_b.col      = col_ext[COL_W-1:0];
    res_b.last     = 1'b1;
  end

  // Slide the window; restart it at each row start and on a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_l_q <= '0;
      win_m_q <= '0;
    end else if (cfg_wr) begin
      win_l_q <= '0;
      win_m_q <= '0;
    end else if (s1_fire) begin
      win_l_q <= s1_ctl_q.col_zero ? '0 : win_m_q;
      win_m_q <= cur_col;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: up to two pushes, one pop per cycle
  // ---------------------------------------------------------------------------
  result_t        oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wptr_q, oq_rptr_q;
  logic [1:0]     n_push;
  logic           pop;
  result_t        head;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    n_push = 2'd0;
    if (s1_fire) begin
      n_push = 2'(has_a) + 2'(has_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (has_a) begin
        oq_mem[oq_wptr_q] <= res_a;
      end
      if (has_b) begin
        oq_mem[oq_wptr_q + OQ_AW'(1)] <= res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q  <= '0;
      oq_rptr_q  <= '0;
      oq_count_q <= '0;
    end else begin
      oq_wptr_q  <= oq_wptr_q + OQ_AW'(n_push);
      oq_rptr_q  <= oq_rptr_q + OQ_AW'(pop);
      oq_count_q <= oq_count_q + (OQ_AW + 1)'(n_push) - (OQ_AW + 1)'(pop);
    end
  end

  assign head        = oq_mem[oq_rptr_q];
  assign out_valid_o = (oq_count_q != '0);
  assign smoothed_o  = head.smoothed;
  assign out_row_o   = head.row;
  assign out_col_o   = head.col;
  assign last_o      = head.last;

endmodule

// ----- sv/g3s_line_buf.sv -----
// Two line stores (rows r-2 and r-1) sharing one address path, registered read.
module g3s_line_buf
  import g3s_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic    clk_i,
  input  logic    rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic    wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  sample_t older_wdata_i,
  input  sample_t newer_wdata_i,
  output sample_t older_rdata_o,
  output sample_t newer_rdata_o
);

  sample_t older_mem [DEPTH];
  sample_t newer_mem [DEPTH];
  sample_t older_rd_q;
  sample_t newer_rd_q;

  // Write back the shifted column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= older_wdata_i;
      newer_mem[wr_addr_i] <= newer_wdata_i;
    end
  end

  // Registered read; hold data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      older_rd_q <= older_mem[rd_addr_i];
      newer_rd_q <= newer_mem[rd_addr_i];
    end
  end

  assign older_rdata_o = older_rd_q;
  assign newer_rdata_o = newer_rd_q;

endmodule
